FILE: design/mbac_pkg.sv
package mbac_pkg;

    localparam int NUM_CH         = 8;
    localparam int SAMPLE_W       = 12;
    localparam int SUM_W          = 16;
    localparam int SIGNED_W       = 13;
    localparam int LINE_W         = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int WINDOW_LEN_DEF = 10;

    localparam logic [SAMPLE_W-1:0] LINE_THR_RST  = 12'd500;
    localparam logic [SAMPLE_W-1:0] GATE_THR_RST  = 12'd0;
    localparam logic [SAMPLE_W-1:0] SERVO_CTR_RST = 12'd0;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_CTR = 2'd2;

    // channel positions within a scan
    localparam int CH_POT       = 0;
    localparam int CH_GATE      = 1;
    localparam int CH_FAR_LEFT  = 2;
    localparam int CH_LEFT      = 3;
    localparam int CH_CENTER    = 4;
    localparam int CH_FAR_RIGHT = 5;
    localparam int CH_RIGHT     = 6;
    localparam int CH_SUPPLY    = 7;

    // line bit positions
    localparam int LINE_FAR_RIGHT = 0;
    localparam int LINE_CENTER    = 1;
    localparam int LINE_FAR_LEFT  = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample line_thr;
        t_sample gate_thr;
        t_sample servo_ctr;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic close;
    } t_lane_ctrl;

    typedef struct packed {
        logic load;
    } t_merge_ctrl;

    typedef struct packed {
        logic stall;
    } t_merge_stat;

endpackage

FILE: design/mbac_in_if.sv
interface mbac_in_if;

    logic                   valid;
    logic                   ready;
    mbac_pkg::t_sample      pot_sample;
    mbac_pkg::t_sample      gate_sample;
    mbac_pkg::t_sample      far_left_sample;
    mbac_pkg::t_sample      left_sample;
    mbac_pkg::t_sample      center_sample;
    mbac_pkg::t_sample      far_right_sample;
    mbac_pkg::t_sample      right_sample;
    mbac_pkg::t_sample      supply_sample;

    modport source (
        output valid, pot_sample, gate_sample, far_left_sample, left_sample,
               center_sample, far_right_sample, right_sample, supply_sample,
        input  ready
    );

    modport sink (
        input  valid, pot_sample, gate_sample, far_left_sample, left_sample,
               center_sample, far_right_sample, right_sample, supply_sample,
        output ready
    );

endinterface

FILE: design/mbac_out_if.sv
interface mbac_out_if;

    logic                                       valid;
    logic                                       ready;
    mbac_pkg::t_sample                          pot_avg;
    mbac_pkg::t_sample                          gate_avg;
    mbac_pkg::t_sample                          far_left_avg;
    mbac_pkg::t_sample                          left_avg;
    mbac_pkg::t_sample                          center_avg;
    mbac_pkg::t_sample                          far_right_avg;
    mbac_pkg::t_sample                          right_avg;
    mbac_pkg::t_sample                          supply_avg;
    logic signed [mbac_pkg::SIGNED_W-1:0]       servo_angle;
    logic signed [mbac_pkg::SIGNED_W-1:0]       lateral_diff;
    logic        [mbac_pkg::LINE_W-1:0]         line_bits;
    logic                                       gate_open;

    modport source (
        output valid, pot_avg, gate_avg, far_left_avg, left_avg, center_avg,
               far_right_avg, right_avg, supply_avg, servo_angle, lateral_diff,
               line_bits, gate_open,
        input  ready
    );

    modport sink (
        input  valid, pot_avg, gate_avg, far_left_avg, left_avg, center_avg,
               far_right_avg, right_avg, supply_avg, servo_angle, lateral_diff,
               line_bits, gate_open,
        output ready
    );

endinterface

FILE: design/mbac_lane.sv
module mbac_lane #(
    parameter int WINDOW_LEN = mbac_pkg::WINDOW_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbac_pkg::t_lane_ctrl    i_ctrl,
    input  mbac_pkg::t_sample       i_sample,
    output mbac_pkg::t_sample       o_avg
);

    localparam int SUM_W   = mbac_pkg::SUM_W;
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W  = 2 * SUM_W + 1;
    // exact reciprocal for any dividend of SUM_W bits
    localparam logic [SUM_W:0] RECIP =
        (SUM_W+1)'(((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    mbac_pkg::t_sample r_avg;
    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.accept) begin
            if (i_ctrl.close) begin
                n_sum = SUM_W'(i_sample);
            end else begin
                n_sum = r_sum + SUM_W'(i_sample);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && i_ctrl.close) begin
            r_avg <= w_prod[SHIFT +: mbac_pkg::SAMPLE_W];
        end
    end

    assign o_avg = r_avg;

endmodule

FILE: design/mbac_merge.sv
module mbac_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbac_pkg::t_merge_ctrl   i_ctrl,
    input  mbac_pkg::t_cfg          i_cfg,
    input  mbac_pkg::t_sample       i_avg [mbac_pkg::NUM_CH],
    output mbac_pkg::t_merge_stat   o_stat,
    mbac_out_if.source              o_result
);

    localparam int SW = mbac_pkg::SIGNED_W;

    logic                           r_valid;
    mbac_pkg::t_sample              r_avg [mbac_pkg::NUM_CH];
    logic signed [SW-1:0]           r_servo_angle;
    logic signed [SW-1:0]           r_lateral_diff;
    logic [mbac_pkg::LINE_W-1:0]    r_line_bits;
    logic                           r_gate_open;
    logic [mbac_pkg::LINE_W-1:0]    w_line;

    always_comb begin
        w_line = '0;
        w_line[mbac_pkg::LINE_FAR_RIGHT] =
            i_avg[mbac_pkg::CH_FAR_RIGHT] < i_cfg.line_thr;
        w_line[mbac_pkg::LINE_CENTER] =
            i_avg[mbac_pkg::CH_CENTER] < i_cfg.line_thr;
        w_line[mbac_pkg::LINE_FAR_LEFT] =
            i_avg[mbac_pkg::CH_FAR_LEFT] < i_cfg.line_thr;
    end

    assign o_stat.stall = r_valid && !o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_avg          <= i_avg;
            r_servo_angle  <= signed'(SW'(i_cfg.servo_ctr)
                              - SW'(i_avg[mbac_pkg::CH_POT]));
            r_lateral_diff <= signed'(SW'(i_avg[mbac_pkg::CH_RIGHT])
                              - SW'(i_avg[mbac_pkg::CH_LEFT]));
            r_line_bits    <= w_line;
            r_gate_open    <= i_avg[mbac_pkg::CH_GATE] <= i_cfg.gate_thr;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.pot_avg       = r_avg[mbac_pkg::CH_POT];
    assign o_result.gate_avg      = r_avg[mbac_pkg::CH_GATE];
    assign o_result.far_left_avg  = r_avg[mbac_pkg::CH_FAR_LEFT];
    assign o_result.left_avg      = r_avg[mbac_pkg::CH_LEFT];
    assign o_result.center_avg    = r_avg[mbac_pkg::CH_CENTER];
    assign o_result.far_right_avg = r_avg[mbac_pkg::CH_FAR_RIGHT];
    assign o_result.right_avg     = r_avg[mbac_pkg::CH_RIGHT];
    assign o_result.supply_avg    = r_avg[mbac_pkg::CH_SUPPLY];
    assign o_result.servo_angle   = r_servo_angle;
    assign o_result.lateral_diff  = r_lateral_diff;
    assign o_result.line_bits     = r_line_bits;
    assign o_result.gate_open     = r_gate_open;

endmodule

FILE: design/multichannel_block_average_classifier.sv
// Boxcar average and threshold classifier for eight converter channels.
// i_scan takes one scan of eight 12-bit samples per request, and every
// WINDOW_LEN-th scan closes a window and produces one request on o_result:
// eight averages (sum / WINDOW_LEN, truncated), servo angle, right-left
// difference, three line bits and the gate flag. Other scans only add in.
// The first window after reset holds WINDOW_LEN-1 scans; the closing scan
// always starts the next window.
// Throughput: one scan per cycle while i_scan.ready is high. The closing
// scan's averages are registered first by the per-lane reciprocal multiply,
// then by the merge stage that compares and subtracts.
// When o_result stalls, the lane average register still holds one more
// closed window; i_scan.ready drops only while both stages are full.
// Reset clears the sums, the scan count and both stages, and loads the
// registers with line threshold 500, gate threshold 0, servo centre 0.
// The user writes registers through i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block does not enforce it.
module multichannel_block_average_classifier #(
    parameter int WINDOW_LEN = mbac_pkg::WINDOW_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  mbac_pkg::t_sample                   i_cfg_data,
    mbac_in_if.sink                             i_scan,
    mbac_out_if.source                          o_result
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_a_valid;
    logic                   n_a_valid;
    mbac_pkg::t_cfg         r_cfg;
    mbac_pkg::t_lane_ctrl   w_lane_ctrl;
    mbac_pkg::t_merge_ctrl  w_merge_ctrl;
    mbac_pkg::t_merge_stat  w_merge_stat;
    mbac_pkg::t_sample      w_sample [mbac_pkg::NUM_CH];
    mbac_pkg::t_sample      w_avg [mbac_pkg::NUM_CH];
    logic                   w_accept;
    logic                   w_close;

    assign i_scan.ready = !r_a_valid || !w_merge_stat.stall;
    assign w_accept     = i_scan.valid && i_scan.ready;
    assign w_close      = r_count == CNT_W'(WINDOW_LEN - 1);

    assign w_lane_ctrl.accept = w_accept;
    assign w_lane_ctrl.close  = w_close;
    assign w_merge_ctrl.load  = r_a_valid && !w_merge_stat.stall;

    assign w_sample[mbac_pkg::CH_POT]       = i_scan.pot_sample;
    assign w_sample[mbac_pkg::CH_GATE]      = i_scan.gate_sample;
    assign w_sample[mbac_pkg::CH_FAR_LEFT]  = i_scan.far_left_sample;
    assign w_sample[mbac_pkg::CH_LEFT]      = i_scan.left_sample;
    assign w_sample[mbac_pkg::CH_CENTER]    = i_scan.center_sample;
    assign w_sample[mbac_pkg::CH_FAR_RIGHT] = i_scan.far_right_sample;
    assign w_sample[mbac_pkg::CH_RIGHT]     = i_scan.right_sample;
    assign w_sample[mbac_pkg::CH_SUPPLY]    = i_scan.supply_sample;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = w_close ? '0 : r_count + CNT_W'(1);
        end
        n_a_valid = r_a_valid;
        if (w_accept && w_close) begin
            n_a_valid = 1'b1;
        end else if (w_merge_ctrl.load) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_thr  <= mbac_pkg::LINE_THR_RST;
            r_cfg.gate_thr  <= mbac_pkg::GATE_THR_RST;
            r_cfg.servo_ctr <= mbac_pkg::SERVO_CTR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbac_pkg::REG_LINE_THR:  r_cfg.line_thr  <= i_cfg_data;
                mbac_pkg::REG_GATE_THR:  r_cfg.gate_thr  <= i_cfg_data;
                mbac_pkg::REG_SERVO_CTR: r_cfg.servo_ctr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < mbac_pkg::NUM_CH; g++) begin : g_lane
        mbac_lane #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_lane_ctrl),
            .i_sample (w_sample[g]),
            .o_avg    (w_avg[g])
        );
    end

    mbac_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_merge_ctrl),
        .i_cfg    (r_cfg),
        .i_avg    (w_avg),
        .o_stat   (w_merge_stat),
        .o_result (o_result)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(WINDOW_LEN))
        else $error("scan count out of range");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_close) |=> (r_count == '0) && r_a_valid)
        else $error("window close not taken");

    a_stage_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_a_valid) |-> $past(w_accept && w_close))
        else $error("average stage filled without a closing scan");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_scan.ready |-> (o_result.valid && !o_result.ready && r_a_valid))
        else $error("scan refused without a full pipeline");

endmodule
